>>> hw/rtl/nearest_palette_color_core_defines.svh
// Assertion macros for the nearest palette color core.
`ifndef NEAREST_PALETTE_COLOR_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define NPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/npc_pkg.sv
// Shared types, constants and helper functions of the nearest palette color core.
package npc_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
	localparam int CH_W = 8;
	localparam int DIST_W = 10;
	localparam int OUT_IDX_W = 8;
	localparam logic [DIST_W-1:0] NO_MATCH = 10'd766;
	localparam logic [CH_W-1:0] GRAY_LIMIT = 8'd3;

	localparam logic [3:0] GRP_RED = 4'b0001;
	localparam logic [3:0] GRP_GREEN = 4'b0010;
	localparam logic [3:0] GRP_BLUE = 4'b0100;
	localparam logic [3:0] GRP_GRAY = 4'b1000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_APPEND = 2'd1,
		OP_CLASSIFY = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} color_t;

	typedef struct packed {
		logic [3:0] mask;
		color_t color;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic [IDX_W-1:0] idx;
		logic [DIST_W-1:0] distance;
		color_t color;
	} best_t;

	function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [3:0] pixel_groups(input color_t c);
		logic [3:0] grp;
		if (absdiff(c.r, c.g) < GRAY_LIMIT && absdiff(c.r, c.b) < GRAY_LIMIT) begin
			grp = GRP_GRAY;
		end else if (c.r == c.g) begin
			grp = GRP_RED | GRP_GREEN;
		end else if (c.r == c.b) begin
			grp = GRP_RED | GRP_BLUE;
		end else if (c.g == c.b) begin
			grp = GRP_GREEN | GRP_BLUE;
		end else if (c.r > c.g && c.r > c.b) begin
			grp = GRP_RED;
		end else if (c.g > c.r && c.g > c.b) begin
			grp = GRP_GREEN;
		end else begin
			grp = GRP_BLUE;
		end
		return grp;
	endfunction

endpackage

>>> hw/rtl/npc_palette_ram.sv
// Palette memory: one write port, one registered read port.
module npc_palette_ram
	import npc_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/npc_scan.sv
// Distance stage and running best-match tracker for the palette scan.
module npc_scan
	import npc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             rd_valid,
	input  logic [IDX_W-1:0] rd_idx,
	input  entry_t           rd_data,
	input  color_t           pixel,
	input  logic [3:0]       want,
	output logic             busy,
	output best_t            best
);

	logic             valid_s2;
	logic             elig_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [DIST_W-1:0] dist_s2;
	color_t           color_s2;
	logic [DIST_W-1:0] dist_c;
	best_t            best_q;

	always_comb begin
		dist_c = DIST_W'(absdiff(pixel.r, rd_data.color.r))
			+ DIST_W'(absdiff(pixel.g, rd_data.color.g))
			+ DIST_W'(absdiff(pixel.b, rd_data.color.b));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= rd_valid;
		end
	end

	always_ff @(posedge clk) begin
		elig_s2  <= (rd_data.mask & want) != 4'd0;
		idx_s2   <= rd_idx;
		dist_s2  <= dist_c;
		color_s2 <= rd_data.color;
	end

	// Strict compare keeps the first entry among equal distances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q.hit <= 1'b0;
			best_q.distance <= NO_MATCH;
			best_q.idx <= '0;
			best_q.color <= '0;
		end else if (start) begin
			best_q.hit <= 1'b0;
			best_q.distance <= NO_MATCH;
			best_q.idx <= '0;
			best_q.color <= '0;
		end else if (valid_s2 && elig_s2 && dist_s2 < best_q.distance) begin
			best_q.hit <= 1'b1;
			best_q.distance <= dist_s2;
			best_q.idx <= idx_s2;
			best_q.color <= color_s2;
		end
	end

	assign busy = valid_s2;
	assign best = best_q;

endmodule

>>> hw/rtl/nearest_palette_color_core.sv
// Nearest palette color core: maps an RGB pixel to the closest loaded palette entry by
// L1 distance among entries that share a color group with the pixel. Beats carry an
// opcode in s_tuser: clear (no result), append (one result) and classify (one result).
// A classify reads the palette memory through its single read port one entry per
// cycle, then waits in the drain state until the scan pipeline is empty; pass-through,
// empty palette and append go straight from idle to the emit state. The next beat can
// be taken in the cycle after a result is loaded into the output register.
// One beat is worked on at a time; a new beat is taken while the previous result waits
// on m_tready.
`include "nearest_palette_color_core_defines.svh"

module nearest_palette_color_core
	import npc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, group_mask, zero pad
	input  logic [1:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // red_out, green_out, blue_out, entry_index, distance, pad
	output logic [1:0]  m_tuser    // found, table_full
);

	typedef struct packed {
		logic found;
		logic table_full;
		color_t color;
		logic [OUT_IDX_W-1:0] idx;
		logic [DIST_W-1:0] distance;
	} res_t;

	state_t state_q, state_d;

	logic             pass_q;
	logic [CNT_W-1:0] entry_count_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             rd_s1;
	logic [IDX_W-1:0] idx_s1;
	color_t           pixel_q;
	logic [3:0]       want_q;
	res_t             res_q;
	logic             m_tvalid_q;
	logic [47:0]      m_tdata_q;
	logic [1:0]       m_tuser_q;

	logic   accept;
	opcode_t op;
	color_t in_color;
	logic [3:0] in_mask;
	logic   full;
	logic   wr_en;
	entry_t wr_data;
	logic   rd_en;
	entry_t rd_data;
	logic   scan_start;
	logic   scan_last;
	logic   scan_busy;
	best_t  best;
	logic   drained;
	logic   out_free;
	logic   out_load;

	assign in_color.r = s_tdata[7:0];
	assign in_color.g = s_tdata[15:8];
	assign in_color.b = s_tdata[23:16];
	assign in_mask = s_tdata[27:24];
	assign op = opcode_t'(s_tuser);

	assign accept = s_tvalid && s_tready;
	assign full = entry_count_q == CNT_W'(PALETTE_DEPTH);
	assign wr_en = accept && op == OP_APPEND && !full;
	assign wr_data = '{mask: in_mask, color: in_color};
	assign scan_start = accept && op == OP_CLASSIFY && !pass_q
		&& entry_count_q != '0;
	assign scan_last = CNT_W'(scan_idx_q) == entry_count_q - CNT_W'(1);
	assign drained = !rd_s1 && !scan_busy;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		rd_en = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (op)
						OP_APPEND: state_d = ST_EMIT;
						OP_CLASSIFY: state_d = scan_start ? ST_SCAN : ST_EMIT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drained) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
		end else if (cfg_we) begin
			pass_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (accept && op == OP_CLEAR) begin
			entry_count_q <= '0;
		end else if (wr_en) begin
			entry_count_q <= entry_count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (scan_start) begin
			scan_idx_q <= '0;
		end else if (rd_en) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
	end

	// Capture each beat's pixel, and its result at accept or when the scan drains.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_q <= in_color;
			want_q <= pixel_groups(in_color);
			if (op == OP_APPEND) begin
				res_q <= '{found: 1'b0, table_full: full, color: '0,
					idx: full ? '0 : OUT_IDX_W'(entry_count_q), distance: '0};
			end else if (op == OP_CLASSIFY && pass_q) begin
				res_q <= '{found: 1'b1, table_full: 1'b0, color: in_color,
					idx: '0, distance: '0};
			end else begin
				res_q <= '0;
			end
		end else if (state_q == ST_DRAIN && drained) begin
			res_q <= '{found: best.hit, table_full: 1'b0, color: best.color,
				idx: OUT_IDX_W'(best.idx), distance: best.hit ? best.distance : '0};
		end
	end

	npc_palette_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entry_count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data)
	);

	npc_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.rd_valid (rd_s1),
		.rd_idx   (idx_s1),
		.rd_data  (rd_data),
		.pixel    (pixel_q),
		.want     (want_q),
		.busy     (scan_busy),
		.best     (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {6'd0, res_q.distance, res_q.idx, res_q.color.b, res_q.color.g,
				res_q.color.r};
			m_tuser_q <= {res_q.table_full, res_q.found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	`NPC_ASSERT_NOW(a_count_bound, 1'b1, entry_count_q <= CNT_W'(PALETTE_DEPTH), "count overflow")
	`NPC_ASSERT_NOW(a_no_write_in_scan, state_q != ST_IDLE, !wr_en, "palette written while busy")
	`NPC_ASSERT_NOW(a_nohit_zero_dist, m_tvalid_q && !m_tuser_q[0], m_tdata_q[41:32] == '0, "no match")
	`NPC_ASSERT_NEXT(a_append_count, wr_en, entry_count_q == $past(entry_count_q) + CNT_W'(1), "count")

endmodule
